@@ rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  localparam int CAPACITY      = 16;
  localparam int PRIORITY_BITS = 8;
  localparam int VALUE_W       = 32;
  localparam int CMD_W         = 2;
  localparam int ERR_W         = 2;
  localparam int IN_PRIO_W     = 8;

  typedef logic [PRIORITY_BITS-1:0] prio_t;
  typedef logic [VALUE_W-1:0]       value_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH  = 2'd0,
    CMD_POP   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_t;

  // Broadcast to every cell for one transaction.
  typedef struct packed {
    logic   push;
    logic   pop;
    value_t value;
    prio_t  prio;
  } cell_op_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic   valid;
    logic   gt;     // holds an entry that outranks the incoming priority
    value_t value;
    prio_t  prio;
  } cell_state_t;

endpackage

@@ rtl/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: command decode, cell chain, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction:
//   push (in_item_value at in_item_priority), pop front, or query. An unused
//   command code behaves as a query.
//   Result channel (out_valid / out_stall) returns one transaction per command:
//   the front data after the command (zero when empty), the empty flag and an
//   error code (push on a full queue is dropped, pop on an empty queue does
//   nothing).
//   Latency: the result is offered the cycle after the command is accepted.
//   Throughput: one command per cycle while no result is stalled; every cell of the chain compares its
//   priority with the incoming one and shifts in the same cycle.
//   Stall: while a result waits under out_stall, in_stall is raised and the
//   queue does not change, so the shown front data stays put.
//   Reset (rst_n low, synchronous): the queue empties and no result is pending.
//   No clearing pass is needed; the block is ready right after reset.
module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic signed [VALUE_W-1:0] in_item_value,
  input  logic [IN_PRIO_W-1:0]    in_item_priority,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VALUE_W-1:0] out_front_value,
  output logic                    out_queue_empty,
  output logic [ERR_W-1:0]        out_op_error
);

  cell_state_t chain [CAPACITY];
  cell_op_t    op;
  logic        accept;
  logic        full;
  logic        empty;
  logic        out_valid_r, out_valid_nxt;
  err_t        err_r, err_nxt;
  logic [CAPACITY-1:0] valid_vec;

  // hold the input while an undelivered result is stalled
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign empty = !chain[0].valid;
  assign full  = chain[CAPACITY-1].valid;

  // decode; illegal pushes and pops never reach the chain
  always_comb begin
    op.push  = 1'b0;
    op.pop   = 1'b0;
    op.value = in_item_value;
    op.prio  = prio_t'(in_item_priority);
    err_nxt  = err_r;
    if (accept) begin
      err_nxt = ERR_NONE;
      case (cmd_t'(in_cmd))
        CMD_PUSH: begin
          if (full) err_nxt = ERR_FULL;
          else      op.push = 1'b1;
        end
        CMD_POP: begin
          if (empty) err_nxt = ERR_EMPTY;
          else       op.pop = 1'b1;
        end
        CMD_QUERY: ;
        default: ;
      endcase
    end
  end

  // cell chain: index 0 is the front
  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      cell_state_t left_s, right_s;
      if (i == 0) begin : g_head
        // the head always takes the new entry unless it outranks it
        assign left_s = '{valid: 1'b1, gt: 1'b1, value: '0, prio: '0};
      end else begin : g_body
        assign left_s = chain[i-1];
      end
      if (i == CAPACITY-1) begin : g_tail
        assign right_s = '{valid: 1'b0, gt: 1'b0, value: '0, prio: '0};
      end else begin : g_inner
        assign right_s = chain[i+1];
      end
      spq_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (op),
        .left  (left_s),
        .right (right_s),
        .own   (chain[i])
      );
      assign valid_vec[i] = chain[i].valid;
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept)         out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      err_r       <= ERR_NONE;
    end else begin
      out_valid_r <= out_valid_nxt;
      err_r       <= err_nxt;
    end
  end

  // chain only moves on accept, so the front reads straight from cell 0
  assign out_valid       = out_valid_r;
  assign out_front_value = empty ? '0 : chain[0].value;
  assign out_queue_empty = empty;
  assign out_op_error    = err_r;

  // occupied cells form an unbroken run from the front
  assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("hole in the cell chain");

  // front never ranks below the second entry
  assert property (@(posedge clk) disable iff (!rst_n)
    chain[1].valid |-> (chain[0].prio >= chain[1].prio))
    else $error("chain out of priority order");

  // a legal push leaves the queue non-empty with no error
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_cmd == CMD_PUSH && !full) |=> (!empty && err_r == ERR_NONE))
    else $error("push did not land");

  // an empty-pop error implies the queue is still empty
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && err_r == ERR_EMPTY) |-> empty)
    else $error("pop error on non-empty queue");

endmodule

@@ rtl/spq_cell.sv @@
// One slot of the sorted chain: holds an entry and shifts toward either neighbor.
module spq_cell
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_op_t    op,
  input  cell_state_t left,
  input  cell_state_t right,
  output cell_state_t own
);

  logic   valid_r, valid_nxt;
  value_t value_r, value_nxt;
  prio_t  prio_r,  prio_nxt;

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    prio_nxt  = prio_r;
    if (op.push) begin
      if (own.gt) begin
        // keep: stays ahead of the new entry
      end else if (left.gt) begin
        valid_nxt = 1'b1;
        value_nxt = op.value;
        prio_nxt  = op.prio;
      end else begin
        valid_nxt = left.valid;
        value_nxt = left.value;
        prio_nxt  = left.prio;
      end
    end else if (op.pop) begin
      valid_nxt = right.valid;
      value_nxt = right.value;
      prio_nxt  = right.prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    prio_r  <= prio_nxt;
  end

  assign own.valid = valid_r;
  assign own.gt    = valid_r && (prio_r > op.prio);
  assign own.value = value_r;
  assign own.prio  = prio_r;

endmodule

@@ tb/sv/sorted_priority_queue_core_test.sv @@
// Self-checking testbench for sorted_priority_queue_core: directed and random push/pop/query traffic.
module sorted_priority_queue_core_test
  import spq_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  // The command code with no operation of its own; the block treats it as a query.
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 500;
  // Once this few commands remain, both sides stop idling.
  localparam int CALM_TAIL = 60;
  // Cycles to watch the result port after the last transaction.
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [CMD_W-1:0]     cmd;
    value_t               value;
    logic [IN_PRIO_W-1:0] prio;
  } pq_command_t;

  typedef struct {
    value_t     front;
    logic       empty;
    logic [1:0] err;
  } pq_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Input channel, driven by the testbench.
  logic                 in_valid = 1'b0;
  logic [CMD_W-1:0]     in_cmd = CMD_QUERY;
  logic [VALUE_W-1:0]   in_item_value = '0;
  logic [IN_PRIO_W-1:0] in_item_priority = '0;
  logic                 in_stall;

  // Result channel.
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [VALUE_W-1:0]   out_front_value;
  logic                 out_queue_empty;
  logic [ERR_W-1:0]     out_op_error;

  sorted_priority_queue_core uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_item_value    (in_item_value),
    .in_item_priority (in_item_priority),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_front_value  (out_front_value),
    .out_queue_empty  (out_queue_empty),
    .out_op_error     (out_op_error)
  );

  // 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Commands waiting to be driven, and results waiting to be seen.
  pq_command_t pending_commands[$];
  pq_result_t  expected_fronts[$];

  int mismatch_count = 0;
  int in_gap_left    = 0;
  int stall_left     = 0;

  // Shadow copy of the queue contents, front first.
  value_t shadow_values[CAPACITY];
  prio_t  shadow_prios[CAPACITY];
  int     shadow_count = 0;

  pq_result_t predicted;
  pq_result_t seen;
  pq_result_t want;

  // Apply one command to the shadow queue and return what the block should report.
  function automatic pq_result_t apply_command(pq_command_t c);
    pq_result_t r;
    prio_t      p;
    int         pos;
    int         i;
    p     = prio_t'(c.prio);
    r.err = ERR_NONE;
    if (c.cmd == CMD_PUSH) begin
      if (shadow_count >= CAPACITY) begin
        r.err = ERR_FULL;
      end else begin
        // New entry goes ahead of everything of lower or equal priority.
        pos = 0;
        while (pos < shadow_count && shadow_prios[pos] > p) pos++;
        for (i = shadow_count; i > pos; i--) begin
          shadow_values[i] = shadow_values[i-1];
          shadow_prios[i]  = shadow_prios[i-1];
        end
        shadow_values[pos] = c.value;
        shadow_prios[pos]  = p;
        shadow_count++;
      end
    end else if (c.cmd == CMD_POP) begin
      if (shadow_count == 0) begin
        r.err = ERR_EMPTY;
      end else begin
        for (i = 0; i + 1 < shadow_count; i++) begin
          shadow_values[i] = shadow_values[i+1];
          shadow_prios[i]  = shadow_prios[i+1];
        end
        shadow_count--;
      end
    end
    // Query and the spare code leave the queue alone.
    if (shadow_count > 0) begin
      r.front = shadow_values[0];
      r.empty = 1'b0;
    end else begin
      r.front = '0;
      r.empty = 1'b1;
    end
    return r;
  endfunction

  task automatic add_command(input logic [CMD_W-1:0] cmd, input value_t value,
                             input logic [IN_PRIO_W-1:0] prio);
    pq_command_t c;
    c.cmd   = cmd;
    c.value = value;
    c.prio  = prio;
    pending_commands.push_back(c);
  endtask

  // Driver: predicts every accepted transaction, then offers the next command
  // or idles. Valid is decided without looking at in_stall except to hold a
  // command that has not been taken yet.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid    <= 1'b0;
      in_gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = apply_command('{cmd: in_cmd, value: in_item_value,
                                    prio: in_item_priority});
        expected_fronts.push_back(predicted);
      end
      if (!in_valid || !in_stall) begin
        if (in_gap_left > 0) begin
          in_gap_left <= in_gap_left - 1;
          in_valid    <= 1'b0;
        end else if (pending_commands.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_commands.size() > CALM_TAIL && $urandom_range(9) == 0) begin
          // Start an idle burst; in_gap_left holds the idle cycles still to come after this one.
          in_gap_left <= $urandom_range(15);
          in_valid    <= 1'b0;
        end else begin
          in_cmd           <= pending_commands[0].cmd;
          in_item_value    <= pending_commands[0].value;
          in_item_priority <= pending_commands[0].prio;
          in_valid         <= 1'b1;
          void'(pending_commands.pop_front());
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction and
  // throws random stall bursts at the block.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen = '{front: out_front_value, empty: out_queue_empty, err: out_op_error};
        if (expected_fronts.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: front=%0d empty=%0b err=%0d",
                     $signed(seen.front), seen.empty, seen.err);
          mismatch_count++;
        end else begin
          want = expected_fronts.pop_front();
          if (seen.front !== want.front || seen.empty !== want.empty ||
              seen.err !== want.err) begin
            if (mismatch_count < 10)
              $display({"result mismatch: front exp %0d got %0d, ",
                        "empty exp %0b got %0b, err exp %0d got %0d"},
                       $signed(want.front), $signed(seen.front), want.empty, seen.empty,
                       want.err, seen.err);
            mismatch_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else if (pending_commands.size() > CALM_TAIL && $urandom_range(7) == 0) begin
        stall_left <= $urandom_range(15);
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int     made;
    int     seg_len;
    int     push_pct;
    bit     narrow;
    int     r;
    int     k;
    value_t v;
    logic [IN_PRIO_W-1:0] p;

    // Directed part: empty-queue errors, spare code, value and priority
    // extremes, equal priorities (newest first), filling up, push when full.
    add_command(CMD_QUERY, 32'h0, 8'h00);
    add_command(CMD_POP,   32'hFFFF_FFFF, 8'hFF);
    add_command(CMD_SPARE, 32'h1234_5678, 8'h5A);
    add_command(CMD_PUSH,  32'h8000_0000, 8'h00);
    add_command(CMD_PUSH,  32'h7FFF_FFFF, 8'hFF);
    add_command(CMD_PUSH,  32'h0000_0001, 8'hFF);
    add_command(CMD_PUSH,  32'hFFFF_FFFF, 8'h00);
    add_command(CMD_QUERY, $urandom, 8'($urandom));
    add_command(CMD_POP,   $urandom, 8'($urandom));
    // Three entries remain; thirteen more fill the queue.
    for (k = 0; k < 13; k++)
      add_command(CMD_PUSH, $urandom, 8'((k * 37) % 256));
    add_command(CMD_PUSH,  32'h5555_AAAA, 8'hFF);
    add_command(CMD_SPARE, 32'hAAAA_5555, 8'h00);
    add_command(CMD_POP,   32'h0, 8'h00);

    // Random part: segments with their own push bias so the fill level
    // sweeps between empty and full; some segments use few priorities to
    // get plenty of ties.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      seg_len  = $urandom_range(10, 40);
      push_pct = $urandom_range(15, 85);
      narrow   = ($urandom_range(2) == 0);
      for (k = 0; k < seg_len && made < RANDOM_ITEMS; k++) begin
        v = $urandom;
        if ($urandom_range(15) == 0) v = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        p = narrow ? 8'($urandom_range(3)) : 8'($urandom_range(255));
        if ($urandom_range(15) == 0) p = $urandom_range(1) ? 8'hFF : 8'h00;
        r = $urandom_range(99);
        if (r < push_pct) begin
          add_command(CMD_PUSH, v, p);
        end else begin
          r = $urandom_range(9);
          if (r == 0)      add_command(CMD_QUERY, v, p);
          else if (r == 1) add_command(CMD_SPARE, v, p);
          else             add_command(CMD_POP, v, p);
        end
        made++;
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_commands.size() != 0 || in_valid) @(posedge clk);
    while (expected_fronts.size() != 0) @(posedge clk);
    // Watch for stray results after the last one.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_fronts.size() == 0) begin
      $display("sorted_priority_queue_core test passed");
    end else begin
      $display("sorted_priority_queue_core test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #400000;
    $display("sorted_priority_queue_core test failed");
    $finish;
  end

endmodule
